FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/tmt_pkg.sv
// ----------------------------------------------------------------------------
// tmt_pkg
// types and constants shared by the message tokenizer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmt_pkg;

    localparam int CHAR_W     = 8;
    localparam int FLEN_W     = 8;
    localparam int SKIP_W     = 2;
    localparam int ITEM_W     = 7;
    localparam int CLASS_W    = 3;
    localparam int OUT_DATA_W = 24;

    // field length limits
    localparam logic [FLEN_W-1:0] SECTION_MAX = 8'd34;
    localparam logic [FLEN_W-1:0] NAME_MAX    = 8'd16;
    localparam logic [FLEN_W-1:0] VALUE_MAX   = 8'd128;

    // delimiter bytes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D;

    localparam logic [ITEM_W-1:0] MIN_ITEMS = 7'd3;

    // byte class codes
    localparam logic [CLASS_W-1:0] CLS_SECTION     = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_NAME        = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_VALUE       = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_SECTION_END = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_NAME_END    = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_ITEM_END    = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_SKIPPED     = 3'd6;
    localparam logic [CLASS_W-1:0] CLS_IGNORED     = 3'd7;

    typedef enum logic [6:0] {
        MODE_SECTION      = 7'b0000001,
        MODE_NAME         = 7'b0000010,
        MODE_VALUE        = 7'b0000100,
        MODE_AFTER        = 7'b0001000,
        MODE_SKIP_NAME    = 7'b0010000,
        MODE_SKIP_SECTION = 7'b0100000,
        MODE_ABORT        = 7'b1000000
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [FLEN_W-1:0]  field_length;
        logic [SKIP_W-1:0]  skip_left;
        logic [ITEM_W-1:0]  item_index;
        logic               overflow;
    } t_state;

    typedef struct packed {
        logic [CLASS_W-1:0] byte_class;
        logic [CHAR_W-1:0]  char_out;
        logic [ITEM_W-1:0]  item_number;
        logic               message_done;
        logic [ITEM_W-1:0]  item_total;
        logic               overflowed;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:         MODE_SECTION,
        field_length: '0,
        skip_left:    '0,
        item_index:   '0,
        overflow:     1'b0
    };

endpackage

FILE: rtl/text_message_tokenizer_unit.sv
// a byte taken into the input register is classified there and moves into the result register once that frees up
// throughput: one byte per cycle while i_m_tready keeps up, limited by the single parser state update
// the input register and the result register each free up when their beat moves on,
// so a new byte is taken while an earlier result waits on i_m_tready
// reset (i_rst_n low, synchronous) empties both registers and returns the parser to
// section mode with zero counts; the parser also resets itself after each last byte
// ----------------------------------------------------------------------------
// text_message_tokenizer_unit
// byte-serial classifier for sectioned name=value text messages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_message_tokenizer_unit #(
    parameter int ITEM_LIMIT = 32    // abort when an item closes with more than this many already closed, 3..63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] char_in
    input  logic                           i_s_tlast,   // is_last
    // classified byte output
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] char_out, [14:8] item_number, [21:15] item_total, [22] overflowed,
    // [23] zero
    output logic [tmt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [2:0]                     o_m_tuser,   // [2:0] byte_class
    output logic                           o_m_tlast    // message_done
);
    import tmt_pkg::*;

    // pipeline control
    logic              out_free;    // result register can take a beat this cycle
    logic              in_valid;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
    logic              fire;        // input beat is classified and moved on

    // parser state and result register
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;

    assign out_free = !r_out_valid || i_m_tready;
    assign fire     = in_valid && out_free;

    tmt_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_advance  (out_free),
        .o_valid    (in_valid),
        .o_char     (in_char),
        .o_last     (in_last)
    );

    tmt_classify #(
        .ITEM_LIMIT (ITEM_LIMIT)
    ) u_classify (
        .i_state      (r_state),
        .i_char       (in_char),
        .i_last       (in_last),
        .o_state_next (n_state),
        .o_result     (n_result)
    );

    // parser state advances once per classified beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // result register, valid bit cleared by reset or when it frees up with no input beat behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_result.overflowed, r_result.item_total,
                         r_result.item_number, r_result.char_out};
    assign o_m_tuser  = r_result.byte_class;
    assign o_m_tlast  = r_result.message_done;

endmodule

FILE: rtl/tmt_in_stage.sv
// ----------------------------------------------------------------------------
// tmt_in_stage
// input register for one message byte with stream handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmt_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [tmt_pkg::CHAR_W-1:0] i_s_tdata,
    input  logic                      i_s_tlast,
    input  logic                      i_advance,
    output logic                      o_valid,
    output logic [tmt_pkg::CHAR_W-1:0] o_char,
    output logic                      o_last
);
    import tmt_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    // free when empty or when the held beat moves on this cycle
    assign o_s_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
            r_last <= i_s_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

FILE: rtl/tmt_classify.sv
// ----------------------------------------------------------------------------
// tmt_classify
// per-byte classification and next parser state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmt_classify #(
    parameter int ITEM_LIMIT = 32
) (
    input  tmt_pkg::t_state             i_state,
    input  logic [tmt_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output tmt_pkg::t_state             o_state_next,
    output tmt_pkg::t_result            o_result
);
    import tmt_pkg::*;

    localparam logic [ITEM_W-1:0] LIMIT = ITEM_W'(ITEM_LIMIT);

    t_state             n_state;
    logic [CLASS_W-1:0] n_class;
    logic               name_end;
    logic [FLEN_W-1:0]  flen_inc;

    assign name_end = (i_char == CH_EQUAL) || (i_char == CH_BANG)
                   || (i_state.field_length == NAME_MAX);
    assign flen_inc = i_state.field_length + 8'd1;

    always_comb begin
        n_state = i_state;
        n_class = CLS_IGNORED;
        case (i_state.mode)
            MODE_SECTION: begin
                if (i_char != CH_NEWLINE && i_state.field_length != SECTION_MAX) begin
                    n_state.field_length = flen_inc;
                    n_class              = CLS_SECTION;
                end else begin
                    n_state.field_length = '0;
                    n_state.skip_left    = 2'd2;
                    n_state.mode         = MODE_SKIP_NAME;
                    n_class              = CLS_SECTION_END;
                end
            end
            MODE_NAME, MODE_AFTER: begin
                if (i_state.mode == MODE_AFTER && i_char == CH_RBRACE) begin
                    n_state.skip_left = 2'd1;
                    n_state.mode      = MODE_SKIP_SECTION;
                    n_class           = CLS_SKIPPED;
                end else if (!name_end) begin
                    n_state.field_length = flen_inc;
                    n_state.mode         = MODE_NAME;
                    n_class              = CLS_NAME;
                end else begin
                    n_state.field_length = '0;
                    n_state.mode         = MODE_VALUE;
                    n_class              = CLS_NAME_END;
                end
            end
            MODE_VALUE: begin
                if (i_char != CH_NEWLINE && i_state.field_length != VALUE_MAX) begin
                    n_state.field_length = flen_inc;
                    n_class              = CLS_VALUE;
                end else begin
                    n_state.field_length = '0;
                    if (i_state.item_index > LIMIT) begin
                        n_state.overflow = 1'b1;
                        n_state.mode     = MODE_ABORT;
                        n_class          = CLS_IGNORED;
                    end else begin
                        n_state.item_index = i_state.item_index + 7'd1;
                        n_state.mode       = MODE_AFTER;
                        n_class            = CLS_ITEM_END;
                    end
                end
            end
            MODE_SKIP_NAME, MODE_SKIP_SECTION: begin
                n_class = CLS_SKIPPED;
                if (i_state.skip_left > 2'd1) begin
                    n_state.skip_left = i_state.skip_left - 2'd1;
                end else begin
                    n_state.skip_left = '0;
                    n_state.mode = (i_state.mode == MODE_SKIP_NAME) ? MODE_NAME : MODE_SECTION;
                end
            end
            default: begin
                n_class = CLS_IGNORED;
            end
        endcase
    end

    always_comb begin
        o_result.byte_class   = n_class;
        o_result.char_out     = i_char;
        o_result.item_number  = i_state.item_index;
        o_result.message_done = i_last;
        o_result.overflowed   = n_state.overflow;
        o_result.item_total   = '0;
        if (i_last && !n_state.overflow && n_state.item_index >= MIN_ITEMS) begin
            o_result.item_total = n_state.item_index;
        end
        o_state_next = i_last ? STATE_RESET : n_state;
    end

endmodule

FILE: rtl/tmt_checker.sv
// ----------------------------------------------------------------------------
// tmt_port_checker
// port-level checks of the tokenizer result stream, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmt_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [tmt_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [2:0]                     o_m_tuser,
    input logic                           o_m_tlast
);
    import tmt_pkg::*;

    logic [ITEM_W-1:0]       total;
    logic                    ovf;
    logic                    stall;
    logic [OUT_DATA_W+3:0]   beat;

    assign total = o_m_tdata[21:15];
    assign ovf   = o_m_tdata[22];
    assign stall = o_m_tvalid && !i_m_tready;
    assign beat  = {o_m_tlast, o_m_tuser, o_m_tdata};

    // a stalled result beat holds
    `ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, stall, o_m_tvalid && $stable(beat))
    // count is reported only on the last byte of a message
    `ASSERT_IMPL(a_total_only_done, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, total == '0)
    // a reported count is never below the minimum and never after overflow
    `ASSERT_IMPL(a_total_legal, i_clk, i_rst_n, o_m_tvalid && total != '0, total >= MIN_ITEMS && !ovf)
    // ignored bytes only come from an aborted message
    `ASSERT_IMPL(a_ignored_ovf, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == CLS_IGNORED, ovf)

endmodule

bind text_message_tokenizer_unit tmt_port_checker u_tmt_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

FILE: tb/sv/tmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmt_checker
// scoreboard for the message tokenizer: tracks parser state from the byte
// beats and compares every classified beat with the predicted one
// ----------------------------------------------------------------------------

module tmt_checker #(
    parameter int ITEM_LIMIT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] char_in
    input  logic                           i_s_tlast,   // is_last
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] char_out, [14:8] item_number, [21:15] item_total, [22] overflowed,
    // [23] zero
    input  logic [tmt_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [2:0]                     i_m_tuser,   // [2:0] byte_class
    input  logic                           i_m_tlast,   // message_done
    output int                             o_fail_count,
    output int                             o_pending
);
    import tmt_pkg::*;

    localparam int PRINT_CAP = 40;

    t_mode                 mode;
    logic [FLEN_W-1:0]     field_len;
    logic [SKIP_W-1:0]     skip_cnt;
    logic [ITEM_W-1:0]     items_closed;
    logic                  aborted;
    t_result               class_q[$];

    task automatic clear_parser();
        mode         = MODE_SECTION;
        field_len    = '0;
        skip_cnt     = '0;
        items_closed = '0;
        aborted      = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < PRINT_CAP) begin
            $display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // name bytes end on '=' or '!' or on the byte after a full name
    task automatic name_char(input logic [7:0] ch, output logic [CLASS_W-1:0] cls);
        if (ch != CH_EQUAL && ch != CH_BANG && field_len != NAME_MAX) begin
            field_len = field_len + 8'd1;
            cls       = CLS_NAME;
        end else begin
            field_len = '0;
            mode      = MODE_VALUE;
            cls       = CLS_NAME_END;
        end
    endtask

    task automatic classify_byte(input logic [7:0] ch, input logic last, output t_result r);
        logic [CLASS_W-1:0] cls;
        cls           = CLS_IGNORED;
        r.char_out    = ch;
        r.item_number = items_closed;
        r.item_total  = '0;
        case (mode)
            MODE_SECTION: begin
                if (ch != CH_NEWLINE && field_len != SECTION_MAX) begin
                    field_len = field_len + 8'd1;
                    cls       = CLS_SECTION;
                end else begin
                    field_len = '0;
                    skip_cnt  = 2'd2;
                    mode      = MODE_SKIP_NAME;
                    cls       = CLS_SECTION_END;
                end
            end
            MODE_NAME: name_char(ch, cls);
            MODE_VALUE: begin
                if (ch != CH_NEWLINE && field_len != VALUE_MAX) begin
                    field_len = field_len + 8'd1;
                    cls       = CLS_VALUE;
                end else begin
                    field_len = '0;
                    if (items_closed > ITEM_LIMIT) begin
                        aborted = 1'b1;
                        mode    = MODE_ABORT;
                        cls     = CLS_IGNORED;
                    end else begin
                        items_closed = items_closed + 7'd1;
                        mode         = MODE_AFTER;
                        cls          = CLS_ITEM_END;
                    end
                end
            end
            MODE_AFTER: begin
                if (ch == CH_RBRACE) begin
                    skip_cnt = 2'd1;
                    mode     = MODE_SKIP_SECTION;
                    cls      = CLS_SKIPPED;
                end else begin
                    mode = MODE_NAME;
                    name_char(ch, cls);
                end
            end
            MODE_SKIP_NAME, MODE_SKIP_SECTION: begin
                cls = CLS_SKIPPED;
                if (skip_cnt > 2'd1) begin
                    skip_cnt = skip_cnt - 2'd1;
                end else begin
                    skip_cnt = '0;
                    mode     = (mode == MODE_SKIP_NAME) ? MODE_NAME : MODE_SECTION;
                end
            end
            default: cls = CLS_IGNORED;
        endcase
        r.byte_class   = cls;
        r.overflowed   = aborted;
        r.message_done = last;
        if (last) begin
            if (!aborted && items_closed >= MIN_ITEMS) begin
                r.item_total = items_closed;
            end
            clear_parser();
        end
    endtask

    always @(posedge i_clk) begin : watch_beats
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            class_q.delete();
            o_fail_count = 0;
        end else begin
            // a result leaves only after its byte has passed the input and result registers, so drain first
            if (i_m_tvalid && i_m_tready) begin
                got.byte_class   = i_m_tuser;
                got.char_out     = i_m_tdata[7:0];
                got.item_number  = i_m_tdata[14:8];
                got.item_total   = i_m_tdata[21:15];
                got.overflowed   = i_m_tdata[22];
                got.message_done = i_m_tlast;
                if (class_q.size() == 0) begin
                    report_mismatch("beat with nothing pending, class", got.byte_class, -1);
                end else begin
                    want = class_q.pop_front();
                    check_field("byte_class", got.byte_class, want.byte_class);
                    check_field("char_out", got.char_out, want.char_out);
                    check_field("item_number", got.item_number, want.item_number);
                    check_field("message_done", got.message_done, want.message_done);
                    check_field("item_total", got.item_total, want.item_total);
                    check_field("overflowed", got.overflowed, want.overflowed);
                    check_field("pad bit", i_m_tdata[23], 0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                classify_byte(i_s_tdata, i_s_tlast, want);
                class_q.push_back(want);
            end
        end
        o_pending = class_q.size();
    end

endmodule

FILE: tb/sv/text_message_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_message_tokenizer_unit_tb
// drives byte messages into the tokenizer: a few hand-built messages, then
// random well-formed messages with broken and noise messages mixed in, under
// three back-pressure profiles; the checker predicts and compares each beat
// ----------------------------------------------------------------------------

module text_message_tokenizer_unit_tb;
    import tmt_pkg::*;

    localparam int ITEM_LIMIT   = 32;
    localparam int PHASE_BYTES  = 100;   // rough byte budget of each phase
    localparam int SETTLE_TICKS = 8;     // idle ticks after the checker queue drains

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_msg_beat;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    // byte side, driven by the stimulus
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic                  s_tlast  = 1'b0;

    // classified side
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [2:0]            m_tuser;
    logic                  m_tlast;

    int                    fail_count;
    int                    pending;

    // idle chances in percent for each side, changed per phase
    int                    tx_idle_pct = 0;
    int                    rx_idle_pct = 0;

    t_msg_beat             msg_q[$];    // message under construction
    t_msg_beat             beat_q[$];   // bytes waiting to go out

    always #4 i_clk = ~i_clk;

    text_message_tokenizer_unit #(
        .ITEM_LIMIT(ITEM_LIMIT)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tlast (m_tlast)
    );

    tmt_checker #(
        .ITEM_LIMIT(ITEM_LIMIT)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // byte driver: a beat is held until taken, then the next one may come or the line goes idle
    always @(posedge i_clk) begin : drive_bytes
        t_msg_beat b;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                b = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.ch;
                s_tlast  <= b.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side stalls at random, independent of whether a beat is waiting
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [7:0] pick_byte_except(input logic [7:0] a, input logic [7:0] b,
                                                    input logic [7:0] c);
        logic [7:0] v;
        v = 8'($urandom);
        while (v == a || v == b || v == c) begin
            v = 8'($urandom);
        end
        return v;
    endfunction

    // mostly short fields, now and then a full one; typ zero keeps fields empty
    function automatic int pick_len(input int max_len, input int typ);
        if (typ > 0 && $urandom_range(99) < 6) begin
            return max_len;
        end
        return $urandom_range(typ);
    endfunction

    task automatic push_byte(input logic [7:0] ch);
        msg_q.push_back('{ch: ch, last: 1'b0});
    endtask

    // mark the final byte and hand the message to the driver
    task automatic flush_message();
        msg_q[$].last = 1'b1;
        foreach (msg_q[i]) begin
            beat_q.push_back(msg_q[i]);
        end
        msg_q.delete();
    endtask

    // section header, its terminator and the two bytes skipped after it
    task automatic open_section(input bit longest);
        int len;
        len = longest ? int'(SECTION_MAX) : pick_len(SECTION_MAX, 8);
        for (int j = 0; j < len; j++) begin
            push_byte(pick_byte_except(CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
        end
        // a full header ends on whatever byte comes next
        push_byte(len == int'(SECTION_MAX) ? 8'($urandom) : CH_NEWLINE);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
    endtask

    // well-formed message of n_items name=value items; longest makes the
    // first section, name and value full length
    task automatic build_message(input int n_items, input bit longest, input int typ);
        int name_len;
        int val_len;
        bit after_item;
        open_section(longest);
        after_item = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            name_len = (longest && k == 0) ? int'(NAME_MAX) : pick_len(NAME_MAX, typ);
            for (int j = 0; j < name_len; j++) begin
                // a closing brace right after an item would leave name mode
                if (j == 0 && after_item) begin
                    push_byte(pick_byte_except(CH_EQUAL, CH_BANG, CH_RBRACE));
                end else begin
                    push_byte(pick_byte_except(CH_EQUAL, CH_BANG, CH_EQUAL));
                end
            end
            if (name_len == int'(NAME_MAX)) begin
                push_byte(8'($urandom));
            end else begin
                push_byte($urandom_range(1) ? CH_EQUAL : CH_BANG);
            end
            val_len = (longest && k == 0) ? int'(VALUE_MAX) : pick_len(VALUE_MAX, typ);
            for (int j = 0; j < val_len; j++) begin
                push_byte(pick_byte_except(CH_NEWLINE, CH_NEWLINE, CH_NEWLINE));
            end
            push_byte(val_len == int'(VALUE_MAX) ? 8'($urandom) : CH_NEWLINE);
            after_item = 1'b1;
            // brace plus one byte goes back to a fresh section
            if (k < n_items - 1 && $urandom_range(99) < 10) begin
                push_byte(CH_RBRACE);
                push_byte(8'($urandom));
                open_section(1'b0);
                after_item = 1'b0;
            end
        end
        // occasional trailing byte so the last beat lands in other modes
        if ($urandom_range(99) < 30) begin
            push_byte(8'($urandom));
        end
    endtask

    task automatic pick_idle(input int ph);
        case (ph)
            0: begin
                tx_idle_pct = 19;
                rx_idle_pct = 53;
            end
            1: begin
                tx_idle_pct = 53;
                rx_idle_pct = 19;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // hand-built messages: extreme byte values, both name terminators,
    // the brace return to section mode, a short item count and a message
    // that ends while skip bytes are still due
    task automatic run_directed();
        logic [7:0] msg_a [20] = '{
            CH_NEWLINE, 8'h00, 8'hFF,                // empty section, two skips
            8'hFF, CH_BANG, 8'h00, CH_NEWLINE,       // first item
            CH_RBRACE, 8'h80,                        // brace then one skipped byte
            8'h7F, CH_NEWLINE, 8'h61, 8'h62,         // second section
            CH_EQUAL, CH_NEWLINE,                    // empty name and value
            8'h78, CH_EQUAL, 8'h76, CH_NEWLINE,      // third item
            8'h7A                                    // last byte as a name byte
        };
        foreach (msg_a[i]) begin
            push_byte(msg_a[i]);
        end
        flush_message();
        push_byte(CH_NEWLINE);
        push_byte(8'h55);
        flush_message();
        push_byte(8'h20);
        flush_message();
    endtask

    initial begin
        int sent;
        int roll;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            pick_idle(ph);
            if (ph == 0) begin
                run_directed();
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                roll = $urandom_range(99);
                if (ph == 1 && sent == 0) begin
                    // enough empty items to run past the limit and abort
                    build_message(ITEM_LIMIT + 2 + $urandom_range(2), 1'b0, 0);
                end else if (ph == 2 && sent == 0) begin
                    build_message(3, 1'b1, 3);
                end else if (roll < 8) begin
                    // noise: bytes with no structure at all
                    repeat ($urandom_range(1, 20)) push_byte(8'($urandom));
                end else begin
                    build_message(($urandom_range(99) < 15) ? $urandom_range(2)
                                                            : $urandom_range(3, 7),
                                  1'b0, 5);
                    // broken message: cut off at a random byte
                    if (roll < 20) begin
                        roll = $urandom_range(1, msg_q.size());
                        while (msg_q.size() > roll) begin
                            void'(msg_q.pop_back());
                        end
                    end
                end
                sent += msg_q.size();
                flush_message();
            end
            while (beat_q.size() != 0 || s_tvalid) begin
                @(negedge i_clk);
            end
        end

        // all bytes are in, wait for the last classified beats
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
